// File: rtl/srsp_pkg.sv
// shared types, character codes and the hex digit decoder for the s-record parser
// no dependencies; used by the channel interfaces and the top level
package srsp_pkg;

  // field widths of the stream words
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;
  localparam int FIELD_AW = 32;

  // parse phase within one record
  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_ADDR = 3'd3,
    PH_DATA = 3'd4,
    PH_CSUM = 3'd5,
    PH_CR   = 3'd6,
    PH_LF   = 3'd7
  } phase_t;

  // record type as reported on the result word
  typedef enum logic [KIND_W-1:0] {
    K_S0   = 2'd0,
    K_S3   = 2'd1,
    K_S7   = 2'd2,
    K_NONE = 2'd3
  } kind_t;

  // record status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_CSUM    = 3'd1,
    ST_FORMAT  = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_END     = 3'd4
  } status_t;

  // result word kinds
  localparam logic ITEM_DATA   = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_S     = 8'h53;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_THREE = 8'h33;
  localparam logic [CHAR_W-1:0] CHAR_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_E     = 8'h45;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_F  = 8'h66;

  // record layout: address and checksum bytes counted by an s3 length byte, s0 header sizes
  localparam logic [7:0] REC_OVERHEAD   = 8'd5;
  localparam logic [7:0] S0_DATA_BYTES  = 8'd11;
  localparam logic [3:0] S0_ADDR_DIGITS = 4'd4;
  localparam logic [3:0] ADDR_DIGITS    = 4'd8;

  // hex digit value, anything that is not a hex digit counts as zero
  function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c[3:0];
    end else if ((c >= CHAR_UC_A && c <= CHAR_UC_F) || (c >= CHAR_LC_A && c <= CHAR_LC_F)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// File: rtl/srsp_in_if.sv
// character channel of the s-record parser: valid, ready and one character word
// depends on srsp_pkg
interface srsp_in_if;
  import srsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface

// File: rtl/srsp_out_if.sv
// result channel of the s-record parser: valid, ready and one result word
// depends on srsp_pkg
interface srsp_out_if;
  import srsp_pkg::*;

  logic                valid;
  logic                ready;
  logic                item_kind;
  logic [STATUS_W-1:0] status;
  logic [KIND_W-1:0]   record_type;
  logic [FIELD_AW-1:0] load_address;
  logic [7:0]          data_byte;
  logic [FIELD_AW-1:0] entry_point;

  modport source (output valid, output item_kind, output status, output record_type,
                  output load_address, output data_byte, output entry_point, input ready);
  modport sink (input valid, input item_kind, input status, input record_type,
                input load_address, input data_byte, input entry_point, output ready);
endinterface

// File: rtl/srecord_stream_parser_unit.sv
// s-record stream parser (S0, S3, S7): one character word in, at most one result word out
// registered: an accepted character word sits in the input register, and its result word then in the
// result register
// throughput: one character per cycle; the result register only holds up input when full
// reset (rst, synchronous): parser waits for 'S', skip flag clear, both registers empty
// depends on srsp_pkg, srsp_in_if and srsp_out_if
module srecord_stream_parser_unit #(
  parameter int ADDRESS_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  srsp_in_if.sink     chars,
  srsp_out_if.source  results
);
  import srsp_pkg::*;

  // input register
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_eoi;

  // parser state
  phase_t                   phase, phase_next;
  kind_t                    kind_seen, kind_seen_next;
  logic [3:0]               digit_count, digit_count_next;
  logic [3:0]               high_nibble, high_nibble_next;
  logic [7:0]               length_byte, length_byte_next;
  logic [ADDRESS_WIDTH-1:0] address_accum, address_accum_next;
  logic [7:0]               running_sum, running_sum_next;
  logic [7:0]               byte_index, byte_index_next;
  logic                     error_skip, error_skip_next;

  // result register
  logic                out_valid;
  logic                out_kind;
  status_t             out_status;
  kind_t               out_type;
  logic [FIELD_AW-1:0] out_load;
  logic [7:0]          out_data;
  logic [FIELD_AW-1:0] out_entry;

  // result of the word in the input register
  logic                res_valid;
  logic                res_kind;
  status_t             res_status;
  kind_t               res_type;
  logic [FIELD_AW-1:0] res_load;
  logic [7:0]          res_data;
  logic [FIELD_AW-1:0] res_entry;

  // shared decode
  logic [3:0]               h;
  logic [7:0]               b;
  logic                     odd;
  logic [3:0]               dc_inc;
  logic [7:0]               bi_inc;
  logic [7:0]               data_count;
  logic [3:0]               addr_limit;
  logic                     s0_bad;
  logic                     type_ok;
  logic                     at_boundary;
  logic [ADDRESS_WIDTH-1:0] addr_sum;
  logic                     out_free;
  logic                     process;

  // handshake: a word is processed when the result register can take its result
  assign out_free     = !out_valid || results.ready;
  assign process      = in_valid && out_free;
  assign chars.ready  = !in_valid || process;

  // field decode of the current character
  assign h          = hex_val(in_char);
  assign odd        = digit_count[0];
  assign b          = {high_nibble, h};
  assign dc_inc     = digit_count + 4'd1;
  assign bi_inc     = byte_index + 8'd1;
  assign addr_limit = (kind_seen == K_S0) ? S0_ADDR_DIGITS : ADDR_DIGITS;
  assign addr_sum   = address_accum + ADDRESS_WIDTH'(byte_index);
  assign type_ok    = (in_char == CHAR_ZERO) || (in_char == CHAR_THREE) ||
                      (in_char == CHAR_SEVEN);
  assign at_boundary = error_skip || (phase == PH_WAIT) || (phase == PH_TYPE);

  always_comb begin
    case (kind_seen)
      K_S0:    data_count = S0_DATA_BYTES;
      K_S3:    data_count = length_byte - REC_OVERHEAD;
      default: data_count = 8'd0;
    endcase
  end

  // fixed header characters of an s0 record
  always_comb begin
    s0_bad = 1'b0;
    if (kind_seen == K_S0) begin
      if (phase == PH_LEN && in_char != (odd ? CHAR_E : CHAR_ZERO)) begin
        s0_bad = 1'b1;
      end
      if (phase == PH_ADDR && in_char != CHAR_ZERO) begin
        s0_bad = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    kind_seen_next     = kind_seen;
    digit_count_next   = digit_count;
    high_nibble_next   = high_nibble;
    length_byte_next   = length_byte;
    address_accum_next = address_accum;
    running_sum_next   = running_sum;
    byte_index_next    = byte_index;
    error_skip_next    = error_skip;
    if (in_eoi) begin
      error_skip_next = 1'b0;
      phase_next      = PH_WAIT;
      kind_seen_next  = K_NONE;
    end else if (error_skip) begin
      if (in_char == CHAR_S) begin
        error_skip_next = 1'b0;
        phase_next      = PH_TYPE;
      end
    end else begin
      unique case (phase)
        PH_WAIT: begin
          if (in_char != CHAR_S) begin
            error_skip_next = 1'b1;
            kind_seen_next  = K_NONE;
          end else begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (!type_ok) begin
            error_skip_next = 1'b1;
            phase_next      = PH_WAIT;
            kind_seen_next  = K_NONE;
          end else begin
            if (in_char == CHAR_ZERO) begin
              kind_seen_next = K_S0;
            end else if (in_char == CHAR_THREE) begin
              kind_seen_next = K_S3;
            end else begin
              kind_seen_next = K_S7;
            end
            digit_count_next   = 4'd0;
            high_nibble_next   = 4'd0;
            length_byte_next   = 8'd0;
            address_accum_next = '0;
            running_sum_next   = 8'd0;
            byte_index_next    = 8'd0;
            phase_next         = PH_LEN;
          end
        end
        PH_CR: begin
          if (in_char != CHAR_CR) begin
            error_skip_next = 1'b1;
            phase_next      = PH_WAIT;
            kind_seen_next  = K_NONE;
          end else begin
            phase_next = PH_LF;
          end
        end
        PH_LF: begin
          if (in_char != CHAR_LF) begin
            error_skip_next = 1'b1;
          end
          phase_next     = PH_WAIT;
          kind_seen_next = K_NONE;
        end
        PH_LEN, PH_ADDR, PH_DATA, PH_CSUM: begin
          if (s0_bad) begin
            error_skip_next = 1'b1;
            phase_next      = PH_WAIT;
            kind_seen_next  = K_NONE;
          end else begin
            if (phase == PH_ADDR) begin
              address_accum_next = {address_accum[ADDRESS_WIDTH-5:0], h};
            end
            if (!odd) begin
              high_nibble_next = h;
            end
            digit_count_next = dc_inc;
            // byte complete on the second digit
            if (odd) begin
              case (phase)
                PH_LEN: begin
                  length_byte_next = b;
                  running_sum_next = running_sum + b;
                  if (kind_seen == K_S3 && b < REC_OVERHEAD) begin
                    error_skip_next = 1'b1;
                    phase_next      = PH_WAIT;
                    kind_seen_next  = K_NONE;
                  end else begin
                    phase_next       = PH_ADDR;
                    digit_count_next = 4'd0;
                  end
                end
                PH_ADDR: begin
                  running_sum_next = running_sum + b;
                  if (dc_inc >= addr_limit) begin
                    digit_count_next = 4'd0;
                    byte_index_next  = 8'd0;
                    phase_next       = (data_count == 8'd0) ? PH_CSUM : PH_DATA;
                  end
                end
                PH_DATA: begin
                  running_sum_next = running_sum + b;
                  byte_index_next  = bi_inc;
                  if (bi_inc >= data_count) begin
                    digit_count_next = 4'd0;
                    phase_next       = PH_CSUM;
                  end
                end
                default: begin
                  // checksum byte leaves zero when it matches
                  running_sum_next = (~running_sum) ^ b;
                  phase_next       = PH_CR;
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res_valid  = 1'b0;
    res_kind   = ITEM_STATUS;
    res_status = ST_OK;
    res_type   = K_NONE;
    res_load   = '0;
    res_data   = 8'd0;
    res_entry  = '0;
    if (in_eoi) begin
      res_valid  = 1'b1;
      res_status = at_boundary ? ST_END : ST_FORMAT;
      res_type   = at_boundary ? K_NONE : kind_seen;
    end else if (!error_skip) begin
      unique case (phase)
        PH_WAIT: begin
          if (in_char != CHAR_S) begin
            res_valid  = 1'b1;
            res_status = ST_FORMAT;
          end
        end
        PH_TYPE: begin
          if (!type_ok) begin
            res_valid  = 1'b1;
            res_status = ST_UNKNOWN;
          end
        end
        PH_CR: begin
          if (in_char != CHAR_CR) begin
            res_valid  = 1'b1;
            res_status = ST_FORMAT;
            res_type   = kind_seen;
          end
        end
        PH_LF: begin
          res_valid = 1'b1;
          res_type  = kind_seen;
          if (in_char != CHAR_LF) begin
            res_status = ST_FORMAT;
          end else begin
            res_status = (running_sum == 8'd0) ? ST_OK : ST_CSUM;
            if (kind_seen == K_S7) begin
              res_entry = FIELD_AW'(address_accum);
            end
          end
        end
        PH_LEN, PH_ADDR, PH_DATA, PH_CSUM: begin
          if (s0_bad) begin
            res_valid  = 1'b1;
            res_status = ST_FORMAT;
            res_type   = K_S0;
          end else if (odd) begin
            if (phase == PH_LEN && kind_seen == K_S3 && b < REC_OVERHEAD) begin
              res_valid  = 1'b1;
              res_status = ST_FORMAT;
              res_type   = K_S3;
            end else if (phase == PH_DATA && kind_seen == K_S3) begin
              res_valid = 1'b1;
              res_kind  = ITEM_DATA;
              res_type  = K_S3;
              res_load  = FIELD_AW'(addr_sum);
              res_data  = b;
            end
          end
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      in_char <= chars.in_char;
      in_eoi  <= chars.end_of_input;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      kind_seen     <= K_NONE;
      digit_count   <= 4'd0;
      high_nibble   <= 4'd0;
      length_byte   <= 8'd0;
      address_accum <= '0;
      running_sum   <= 8'd0;
      byte_index    <= 8'd0;
      error_skip    <= 1'b0;
    end else if (process) begin
      phase         <= phase_next;
      kind_seen     <= kind_seen_next;
      digit_count   <= digit_count_next;
      high_nibble   <= high_nibble_next;
      length_byte   <= length_byte_next;
      address_accum <= address_accum_next;
      running_sum   <= running_sum_next;
      byte_index    <= byte_index_next;
      error_skip    <= error_skip_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && res_valid) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (process && res_valid) begin
      out_kind   <= res_kind;
      out_status <= res_status;
      out_type   <= res_type;
      out_load   <= res_load;
      out_data   <= res_data;
      out_entry  <= res_entry;
    end
  end

  assign results.valid        = out_valid;
  assign results.item_kind    = out_kind;
  assign results.status       = out_status;
  assign results.record_type  = out_type;
  assign results.load_address = out_load;
  assign results.data_byte    = out_data;
  assign results.entry_point  = out_entry;

  // data words only come from s3 records
  a_data_is_s3: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.item_kind == ITEM_DATA) |->
      (results.record_type == K_S3 && results.status == ST_OK))
    else $error("data word outside an s3 record");

  // entry point only on an s7 status
  a_entry_s7: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.record_type != K_S7) |-> (results.entry_point == '0))
    else $error("entry point set outside s7 status");

  // skipping always leaves the parser at a record boundary
  a_skip_phase: assert property (@(posedge clk) disable iff (rst)
    error_skip |-> (phase == PH_WAIT))
    else $error("skip flag set inside a record");

  // address digit count never runs past eight
  a_addr_digits: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ADDR) |-> (digit_count <= ADDR_DIGITS))
    else $error("address digit count overrun");

endmodule
